// ----- hdl/plist_pkg.sv -----
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int DefCapacity = 16;
  localparam int MaxResults  = 16;
  localparam int ValueW      = 32;
  localparam int PosW        = 8;
  localparam int CountW      = 5;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BADPOS = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_e;

  // Source select of one list cell
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_BUS
  } sel_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } fsm_e;

  typedef struct packed {
    op_e                    op;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]        position;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic [CountW-1:0]      count;
    logic signed [ValueW-1:0] element;
    logic                   element_valid;
    logic                   last;
  } out_t;

endpackage

// ----- hdl/plist_cell.sv -----
// ----------------------------------------------------------------------------
// plist_cell
// One list slot: loads from its left or right neighbor, the bus, or holds.
// ----------------------------------------------------------------------------
module plist_cell import plist_pkg::*; (
  input  logic                     clk_i,
  input  sel_e                     sel_i,
  input  logic signed [ValueW-1:0] left_i,
  input  logic signed [ValueW-1:0] right_i,
  input  logic signed [ValueW-1:0] bus_i,
  output logic signed [ValueW-1:0] data_o
);

  logic signed [ValueW-1:0] data_q, data_d;

  always_comb begin
    unique case (sel_i)
      SEL_LEFT:  data_d = left_i;
      SEL_RIGHT: data_d = right_i;
      SEL_BUS:   data_d = bus_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hdl/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// An edit result is registered: it is in the output register in the cycle after its beat.
// Edits are taken one per cycle while idle and the output is free; a dump of n
// elements emits min(n, MaxResults) beats, and input stalls until it is done.
// Reset clears the element count, the sequencer and the output valid; the
// cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module positional_list_engine import plist_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_beat_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_beat_o
);

  localparam int OccW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);
  // Compare width wide enough for the position field and the count plus one
  localparam int CW   = ((OccW > PosW) ? OccW : PosW) + 1;

  // Element count and dump sequencer
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] step_q, step_d;
  fsm_e            state_q, state_d;

  // Output register
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic load_out;
  logic out_free;

  // Cell row
  logic signed [ValueW-1:0] cell_data [CAPACITY];
  sel_e                     cell_sel  [CAPACITY];
  logic signed [ValueW-1:0] bus;

  // Broadcast command to the row
  cmd_e            cmd;
  logic [IdxW-1:0] idx;

  logic in_accept;
  logic dump_emit;
  logic dump_adv;
  logic dump_last_step;

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] occ_ext;
  logic [CW-1:0] step_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != FSM_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pos_ext  = CW'(in_beat_i.position);
  assign occ_ext  = CW'(occ_q);
  assign step_ext = CW'(step_q);

  // Dump: emit the head while fewer than MaxResults beats went out, then
  // keep rotating silently so the ring comes back to its original order.
  assign dump_emit      = step_ext < CW'(MaxResults);
  assign dump_adv       = (state_q == FSM_DUMP) && (!dump_emit || out_free);
  assign dump_last_step = (step_ext + CW'(1)) == occ_ext;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_accept && (in_beat_i.op == OP_DUMP) && (occ_q != '0)) begin
          state_d = FSM_DUMP;
        end
      end
      FSM_DUMP: begin
        if (dump_adv && dump_last_step) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Command decode and result build
  always_comb begin
    cmd      = CMD_NONE;
    idx      = '0;
    occ_d    = occ_q;
    step_d   = step_q;
    load_out = 1'b0;
    out_d    = '{status: STATUS_OK, count: '0, element: '0, element_valid: 1'b0,
                 last: 1'b1};

    unique case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          unique case (in_beat_i.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              load_out = 1'b1;
              // Full check comes before the position check
              if (occ_q == OccW'(CAPACITY)) begin
                out_d.status = STATUS_FULL;
              end else if ((in_beat_i.op == OP_INS_AT) &&
                           ((pos_ext == '0) || (pos_ext > occ_ext + CW'(1)))) begin
                out_d.status = STATUS_BADPOS;
              end else begin
                cmd   = CMD_INSERT;
                occ_d = occ_q + OccW'(1);
                if (in_beat_i.op == OP_INS_FRONT) begin
                  idx = '0;
                end else if (in_beat_i.op == OP_INS_BACK) begin
                  idx = IdxW'(occ_q);
                end else begin
                  idx = IdxW'(pos_ext - CW'(1));
                end
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
              load_out = 1'b1;
              // Empty check comes before the position check
              if (occ_q == '0) begin
                out_d.status = STATUS_EMPTY;
              end else if ((in_beat_i.op == OP_DEL_AT) &&
                           ((pos_ext == '0) || (pos_ext > occ_ext))) begin
                out_d.status = STATUS_BADPOS;
              end else begin
                cmd   = CMD_DELETE;
                occ_d = occ_q - OccW'(1);
                if (in_beat_i.op == OP_DEL_FRONT) begin
                  idx = '0;
                end else if (in_beat_i.op == OP_DEL_BACK) begin
                  idx = IdxW'(occ_q - OccW'(1));
                end else begin
                  idx = IdxW'(pos_ext - CW'(1));
                end
              end
            end
            OP_DUMP: begin
              step_d = '0;
              // Empty list: one beat with no element
              if (occ_q == '0) begin
                load_out     = 1'b1;
                out_d.status = STATUS_EMPTY;
              end
            end
            default: begin
              // Unused code: drop the beat, no result
            end
          endcase
          out_d.count = CountW'(occ_d);
        end
      end
      FSM_DUMP: begin
        if (dump_adv) begin
          cmd    = CMD_ROTATE;
          step_d = step_q + OccW'(1);
          if (dump_emit) begin
            load_out            = 1'b1;
            out_d.status        = STATUS_OK;
            out_d.count         = CountW'(occ_q);
            out_d.element       = cell_data[0];
            out_d.element_valid = 1'b1;
            out_d.last          = dump_last_step ||
                                  ((step_ext + CW'(1)) == CW'(MaxResults));
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Per-cell select: each cell compares its own index with the command
  assign bus = (cmd == CMD_ROTATE) ? cell_data[0] : in_beat_i.value;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_sel[i] = SEL_HOLD;
      unique case (cmd)
        CMD_INSERT: begin
          if (IdxW'(i) == idx) begin
            cell_sel[i] = SEL_BUS;
          end else if ((IdxW'(i) > idx) && (OccW'(i) <= occ_q)) begin
            cell_sel[i] = SEL_LEFT;
          end
        end
        CMD_DELETE: begin
          if ((IdxW'(i) >= idx) && ((OccW'(i) + OccW'(1)) < occ_q)) begin
            cell_sel[i] = SEL_RIGHT;
          end
        end
        CMD_ROTATE: begin
          // Advance the ring: head wraps around to the tail slot
          if ((OccW'(i) + OccW'(1)) < occ_q) begin
            cell_sel[i] = SEL_RIGHT;
          end else if ((OccW'(i) + OccW'(1)) == occ_q) begin
            cell_sel[i] = SEL_BUS;
          end
        end
        default: cell_sel[i] = SEL_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ValueW-1:0] left_w;
    logic signed [ValueW-1:0] right_w;

    // Edge cells never pick the missing neighbor
    if (g == 0) begin : g_first
      assign left_w = bus;
    end else begin : g_left
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_w = cell_data[g];
    end else begin : g_right
      assign right_w = cell_data[g+1];
    end

    plist_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (cell_sel[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .bus_i   (bus),
      .data_o  (cell_data[g])
    );
  end

  // Hold the result until taken
  assign out_valid_d = out_free ? load_out : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      occ_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ----- hdl/plist_checker.sv -----
// ----------------------------------------------------------------------------
// plist_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module plist_checker import plist_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_beat_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_beat_o
);

  // A stalled input beat stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_beat_i))
    else $error("input beat changed while stalled");

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Dumped elements always carry ok status
  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.element_valid |-> out_beat_o.status == STATUS_OK)
    else $error("element beat with non-ok status");

  // Edit results and the empty dump are single beats
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.element_valid |-> out_beat_o.last)
    else $error("non-element beat without last");

  // Empty status implies an empty list
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == STATUS_EMPTY) |-> out_beat_o.count == '0)
    else $error("empty status with nonzero count");

endmodule

bind positional_list_engine plist_checker u_plist_checker (.*);
